// ===== hdl/imsf_pkg.sv =====
// Shared types, codes, markup tables and the prefix classifier for the markup strip filter.
package imsf_pkg;

  localparam int BYTE_W     = 8;
  localparam int HOLD_SLOTS = 7;   // six held bytes plus the incoming one
  localparam int CNT_W      = 3;
  localparam int NUM_MARKS  = 7;
  localparam int MARK_MAX   = 7;

  localparam logic [BYTE_W-1:0] CHAR_NUL = 8'h00;
  localparam logic [BYTE_W-1:0] CHAR_LF  = 8'h0a;
  localparam logic [BYTE_W-1:0] CHAR_CR  = 8'h0d;
  localparam logic [BYTE_W-1:0] CHAR_ESC = 8'h1b;
  localparam logic [BYTE_W-1:0] CHAR_GT  = 8'h3e;
  localparam logic [BYTE_W-1:0] CHAR_M   = 8'h6d;

  // Skip modes
  localparam logic [1:0] SKIP_NONE  = 2'd0;
  localparam logic [1:0] SKIP_TO_GT = 2'd1;
  localparam logic [1:0] SKIP_TO_M  = 2'd2;
  localparam logic [1:0] SKIP_BAD   = 2'd3;

  // Classifier results
  localparam logic [1:0] CLS_NONE   = 2'd0;
  localparam logic [1:0] CLS_PREFIX = 2'd1;
  localparam logic [1:0] CLS_MATCH  = 2'd2;

  // Output register load selects
  localparam logic [1:0] EMIT_NONE = 2'd0;
  localparam logic [1:0] EMIT_LF   = 2'd1;
  localparam logic [1:0] EMIT_HEAD = 2'd2;
  localparam logic [1:0] EMIT_TERM = 2'd3;

  // Markup texts, lower case, zero padded
  localparam logic [BYTE_W-1:0] MARK_TEXT [NUM_MARKS][MARK_MAX] = '{
    '{"<", "f", "o", "n", "t", " ", CHAR_NUL},
    '{"<", "/", "f", "o", "n", "t", CHAR_NUL},
    '{"<", "f", "a", "d", "e", " ", CHAR_NUL},
    '{"<", "/", "f", "a", "d", "e", ">"},
    '{"<", "a", "l", "t", " ", CHAR_NUL, CHAR_NUL},
    '{"<", "/", "a", "l", "t", ">", CHAR_NUL},
    '{CHAR_ESC, "[", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL}
  };
  localparam logic [CNT_W-1:0] MARK_LEN [NUM_MARKS] = '{
    3'd6, 3'd6, 3'd6, 3'd7, 3'd5, 3'd6, 3'd2
  };
  localparam logic [1:0] MARK_SKIP [NUM_MARKS] = '{
    SKIP_TO_GT, SKIP_TO_GT, SKIP_TO_GT, SKIP_NONE, SKIP_TO_GT, SKIP_NONE, SKIP_TO_M
  };

  typedef logic [HOLD_SLOTS-1:0][BYTE_W-1:0] hold_t;

  typedef struct packed {
    logic [1:0] cls;
    logic [1:0] kind;
  } class_t;

  // Controller to datapath
  typedef struct packed {
    logic       skip_step;
    logic       append;
    logic [1:0] emit;
    logic       mark_owed;
    logic       start_skip;
  } imsf_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic       in_zero;
    logic       in_lf;
    logic       skipping;
    logic       owed;
    logic [1:0] cls;
    logic       one_left;
    logic       holds_any;
    logic       can_load;
  } imsf_sts_t;

  // Lower-case ASCII letters only
  function automatic logic [BYTE_W-1:0] fold(input logic [BYTE_W-1:0] c);
    if (c >= "A" && c <= "Z") begin
      return c + 8'd32;
    end
    return c;
  endfunction

  // Compare the held bytes against every mark in parallel
  function automatic class_t classify(input hold_t held, input logic [CNT_W-1:0] cnt);
    class_t res;
    logic   same;
    logic   found;
    res.cls  = CLS_NONE;
    res.kind = SKIP_NONE;
    found    = 1'b0;
    for (int m = 0; m < NUM_MARKS; m++) begin
      same = (cnt <= MARK_LEN[m]);
      for (int i = 0; i < MARK_MAX; i++) begin
        if (CNT_W'(i) < cnt && fold(held[i]) != MARK_TEXT[m][i]) begin
          same = 1'b0;
        end
      end
      if (same && !found) begin
        if (cnt == MARK_LEN[m]) begin
          found    = 1'b1;
          res.cls  = CLS_MATCH;
          res.kind = MARK_SKIP[m];
        end else begin
          res.cls = CLS_PREFIX;
        end
      end
    end
    return res;
  endfunction

endpackage

// ===== hdl/im_markup_strip_filter_top.sv =====
// Top level of the markup strip filter: controller plus datapath.
// A plain byte is appended to the held bytes on acceptance and loaded into the output
// register in the scan step that follows. Input stalls outside the idle state: for the
// scan step, for each held byte released on a mismatch and for an owed line feed; a byte
// inside markup is taken with no scan step.
// End of message emits the owed line feed, then each held byte, then the terminator.
// Reset (rst, synchronous): no held bytes, no skip, no owed line feed, output empty.
module im_markup_strip_filter_top (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [imsf_pkg::BYTE_W-1:0] in_byte,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [imsf_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_last
);
  import imsf_pkg::*;

  imsf_cmd_t cmd;
  imsf_sts_t sts;

  imsf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  imsf_datapath u_datapath (
    .clk       (clk),
    .rst       (rst),
    .in_byte   (in_byte),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

endmodule

// ===== hdl/imsf_datapath.sv =====
// Datapath of the markup strip filter: held bytes, skip and line feed state, output register.
module imsf_datapath (
  input  logic                       clk,
  input  logic                       rst,
  input  logic [imsf_pkg::BYTE_W-1:0] in_byte,
  input  imsf_pkg::imsf_cmd_t        cmd,
  output imsf_pkg::imsf_sts_t        sts,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [imsf_pkg::BYTE_W-1:0] out_byte,
  output logic                       out_last
);
  import imsf_pkg::*;

  hold_t             held;
  logic [CNT_W-1:0]  count;
  logic [1:0]        skip_mode;
  logic              owed_lf;
  class_t            cls_now;
  logic              skip_done;
  logic [BYTE_W-1:0] emit_byte;

  // Classify the held bytes
  assign cls_now = classify(held, count);

  // Detect the byte that closes a skip
  assign skip_done = (skip_mode == SKIP_TO_GT && in_byte == CHAR_GT) ||
                     (skip_mode == SKIP_TO_M && in_byte == CHAR_M) ||
                     (skip_mode == SKIP_BAD);

  // Select the byte for the output register
  always_comb begin
    case (cmd.emit)
      EMIT_LF:   emit_byte = CHAR_LF;
      EMIT_HEAD: emit_byte = held[0];
      EMIT_TERM: emit_byte = CHAR_NUL;
      default:   emit_byte = held[0];
    endcase
  end

  // Report status
  always_comb begin
    sts.in_zero   = (in_byte == CHAR_NUL);
    sts.in_lf     = (in_byte == CHAR_LF);
    sts.skipping  = (skip_mode != SKIP_NONE);
    sts.owed      = owed_lf;
    sts.cls       = cls_now.cls;
    sts.one_left  = (count == CNT_W'(1));
    sts.holds_any = (count != '0);
    sts.can_load  = !out_valid || !out_stall;
  end

  // Update control state
  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      skip_mode <= SKIP_NONE;
      owed_lf   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.skip_step && skip_done) begin
        skip_mode <= SKIP_NONE;
      end
      if (cmd.append) begin
        count   <= count + CNT_W'(1);
        owed_lf <= 1'b0;
      end
      if (cmd.start_skip) begin
        count     <= '0;
        skip_mode <= cls_now.kind;
      end
      case (cmd.emit)
        EMIT_HEAD: begin
          count <= count - CNT_W'(1);
          if (cmd.mark_owed && held[0] == CHAR_CR) begin
            owed_lf <= 1'b1;
          end
        end
        EMIT_TERM: begin
          count     <= '0;
          skip_mode <= SKIP_NONE;
          owed_lf   <= 1'b0;
        end
        default: ;
      endcase
      if (cmd.emit != EMIT_NONE) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Hold, append and shift bytes; load the output register
  always_ff @(posedge clk) begin
    if (cmd.append) begin
      held[count] <= in_byte;
    end
    if (cmd.emit == EMIT_HEAD) begin
      for (int i = 0; i < HOLD_SLOTS - 1; i++) begin
        held[i] <= held[i+1];
      end
    end
    if (cmd.emit != EMIT_NONE) begin
      out_byte <= emit_byte;
      out_last <= (cmd.emit == EMIT_TERM);
    end
  end

  a_append_room: assert property (@(posedge clk) disable iff (rst)
    cmd.append |-> count != CNT_W'(HOLD_SLOTS))
    else $error("append with no free hold slot");

  a_cr_is_last: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit == EMIT_HEAD && cmd.mark_owed && held[0] == CHAR_CR) |-> count == CNT_W'(1))
    else $error("carriage return emitted with bytes still held behind it");

  a_term_clears: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit == EMIT_TERM) |=> (count == '0 && skip_mode == SKIP_NONE && !owed_lf && out_last))
    else $error("terminator did not return state to idle values");

endmodule

// ===== hdl/imsf_ctrl.sv =====
// Controller state machine of the markup strip filter.
module imsf_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  imsf_pkg::imsf_sts_t sts,
  output imsf_pkg::imsf_cmd_t cmd
);
  import imsf_pkg::*;

  localparam logic [2:0] S_IDLE      = 3'd0;
  localparam logic [2:0] S_LF        = 3'd1;
  localparam logic [2:0] S_SCAN      = 3'd2;
  localparam logic [2:0] S_END_LF    = 3'd3;
  localparam logic [2:0] S_END_FLUSH = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       accept;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  // Decode state and status into commands
  always_comb begin
    state_next     = state;
    cmd.skip_step  = 1'b0;
    cmd.append     = 1'b0;
    cmd.emit       = EMIT_NONE;
    cmd.mark_owed  = 1'b0;
    cmd.start_skip = 1'b0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (sts.in_zero) begin
            state_next = sts.owed ? S_END_LF : S_END_FLUSH;
          end else if (sts.skipping) begin
            cmd.skip_step = 1'b1;
          end else begin
            cmd.append = 1'b1;
            state_next = (sts.owed && !sts.in_lf) ? S_LF : S_SCAN;
          end
        end
      end
      S_LF: begin
        if (sts.can_load) begin
          cmd.emit   = EMIT_LF;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        case (sts.cls)
          CLS_MATCH: begin
            cmd.start_skip = 1'b1;
            state_next     = S_IDLE;
          end
          CLS_PREFIX: begin
            state_next = S_IDLE;
          end
          default: begin
            if (sts.can_load) begin
              cmd.emit      = EMIT_HEAD;
              cmd.mark_owed = 1'b1;
              if (sts.one_left) begin
                state_next = S_IDLE;
              end
            end
          end
        endcase
      end
      S_END_LF: begin
        if (sts.can_load) begin
          cmd.emit   = EMIT_LF;
          state_next = S_END_FLUSH;
        end
      end
      S_END_FLUSH: begin
        if (sts.can_load) begin
          if (sts.holds_any) begin
            cmd.emit = EMIT_HEAD;
          end else begin
            cmd.emit   = EMIT_TERM;
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Advance state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  a_emit_room: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit != EMIT_NONE) |-> sts.can_load)
    else $error("output register loaded while still full and stalled");

  a_end_path: assert property (@(posedge clk) disable iff (rst)
    (accept && sts.in_zero) |=> (state == S_END_LF || state == S_END_FLUSH))
    else $error("end of message did not enter the flush sequence");

  a_skip_from_scan: assert property (@(posedge clk) disable iff (rst)
    cmd.start_skip |-> (state == S_SCAN && sts.cls == CLS_MATCH))
    else $error("skip started outside a full markup match");

endmodule

// ===== sim/tb_im_markup_strip_filter_top.sv =====
// Self-checking testbench for the markup strip filter: directed and random messages.
`timescale 1ns / 100ps

import imsf_pkg::*;

typedef struct packed {
  logic [BYTE_W-1:0] ch;
  logic              last;
} strip_out_t;

// Track the filter state and hold the bytes it still owes on its output
class markup_strip_checker;
  string             mark_txt [7];
  logic [1:0]        mark_skip [7];
  logic [BYTE_W-1:0] held [6];
  int                held_cnt;
  logic [1:0]        skip_mode;
  bit                lf_owed;
  strip_out_t        filtered_q [$];
  int                err_count;

  function new();
    mark_txt  = '{"<font ", "</font", "<fade ", "</fade>", "<alt ", "</alt>", "\033["};
    mark_skip = '{SKIP_TO_GT, SKIP_TO_GT, SKIP_TO_GT, SKIP_NONE, SKIP_TO_GT, SKIP_NONE,
                  SKIP_TO_M};
    held_cnt  = 0;
    skip_mode = SKIP_NONE;
    lf_owed   = 1'b0;
    err_count = 0;
  endfunction

  function logic [BYTE_W-1:0] lower(logic [BYTE_W-1:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // Classify the first n window bytes against all marks; a whole mark wins
  function logic [1:0] match_marks(logic [BYTE_W-1:0] win [7], int n,
                                   output logic [1:0] kind);
    logic [1:0] res;
    bit         same;
    res  = CLS_NONE;
    kind = SKIP_NONE;
    for (int m = 0; m < 7; m++) begin
      if (n <= mark_txt[m].len()) begin
        same = 1'b1;
        for (int i = 0; i < n; i++) begin
          if (lower(win[i]) != mark_txt[m][i]) begin
            same = 1'b0;
          end
        end
        if (same && n == mark_txt[m].len()) begin
          kind = mark_skip[m];
          return CLS_MATCH;
        end
        if (same) begin
          res = CLS_PREFIX;
        end
      end
    end
    return res;
  endfunction

  function void owe(logic [BYTE_W-1:0] c, logic last);
    strip_out_t item;
    item.ch   = c;
    item.last = last;
    filtered_q.push_back(item);
  endfunction

  // Advance the filter by one accepted input transaction
  function void filter_byte(logic [BYTE_W-1:0] b);
    logic [BYTE_W-1:0] win [7];
    int                n;
    logic [1:0]        kind;
    logic [1:0]        cls;
    // End of message: flush owed LF and held bytes, then terminate
    if (b == CHAR_NUL) begin
      if (lf_owed) begin
        owe(CHAR_LF, 1'b0);
      end
      for (int i = 0; i < held_cnt; i++) begin
        owe(held[i], 1'b0);
      end
      owe(CHAR_NUL, 1'b1);
      held_cnt  = 0;
      skip_mode = SKIP_NONE;
      lf_owed   = 1'b0;
      return;
    end
    // Drop bytes inside markup
    if (skip_mode != SKIP_NONE) begin
      if ((skip_mode == SKIP_TO_GT && b == CHAR_GT) ||
          (skip_mode == SKIP_TO_M && b == CHAR_M)) begin
        skip_mode = SKIP_NONE;
      end
      return;
    end
    if (lf_owed) begin
      lf_owed = 1'b0;
      if (b != CHAR_LF) begin
        owe(CHAR_LF, 1'b0);
      end
    end
    for (int i = 0; i < held_cnt; i++) begin
      win[i] = held[i];
    end
    win[held_cnt] = b;
    n = held_cnt + 1;
    // Release the head byte on each mismatch and rescan the rest
    while (n > 0) begin
      cls = match_marks(win, n, kind);
      if (cls == CLS_MATCH) begin
        n         = 0;
        skip_mode = kind;
        break;
      end
      if (cls == CLS_PREFIX) begin
        break;
      end
      owe(win[0], 1'b0);
      if (win[0] == CHAR_CR) begin
        lf_owed = 1'b1;
      end
      for (int i = 0; i < n - 1; i++) begin
        win[i] = win[i + 1];
      end
      n--;
    end
    for (int i = 0; i < n; i++) begin
      held[i] = win[i];
    end
    held_cnt = n;
  endfunction

  function void flag(string what, logic [BYTE_W-1:0] ch, logic last, strip_out_t want);
    err_count++;
    if (err_count <= 10) begin
      $display("%s: out_byte %02h out_last %0d, expected %02h / %0d",
               what, ch, last, want.ch, want.last);
    end
  endfunction

  // Compare one output transaction with the oldest owed byte
  function void check_filtered(logic [BYTE_W-1:0] ch, logic last);
    strip_out_t want;
    if (filtered_q.size() == 0) begin
      want = '0;
      flag("unexpected output", ch, last, want);
      return;
    end
    want = filtered_q.pop_front();
    if (want.ch !== ch || want.last !== last) begin
      flag("mismatch", ch, last, want);
    end
  endfunction
endclass

module tb_im_markup_strip_filter_top;

  localparam int CLK_PERIOD      = 10;
  localparam int RAND_PER_PHASE  = 40;
  localparam int HOLD_OFF_CYCLES = 80;
  localparam int TAIL_CYCLES     = 16;
  localparam int CYCLE_LIMIT     = 200000;

  logic              clk       = 1'b0;
  logic              rst       = 1'b1;
  logic              in_valid  = 1'b0;
  logic              in_stall;
  logic [BYTE_W-1:0] in_byte   = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [BYTE_W-1:0] out_byte;
  logic              out_last;

  markup_strip_checker strip_sb;
  int                  send_idle_pct = 9;
  int                  recv_idle_pct = 51;
  bit                  hold_off_req  = 1'b0;
  int                  hold_left     = 0;
  int                  cycle_cnt     = 0;
  int                  items_sent    = 0;
  logic [BYTE_W-1:0]   msg_q [$];

  always #(CLK_PERIOD / 2) clk = ~clk;

  im_markup_strip_filter_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_byte   (in_byte),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .out_last  (out_last)
  );

  // Check output transactions and stall the output at random or for a long hold
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) begin
      strip_sb.check_filtered(out_byte, out_last);
    end
    if (hold_off_req) begin
      hold_left    = HOLD_OFF_CYCLES;
      hold_off_req = 1'b0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  // Bound the run
  initial begin
    while (cycle_cnt < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("tb: failure");
    $finish;
  end

  // Offer one byte after optional idle cycles; hold it until accepted
  task automatic send_byte(logic [BYTE_W-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_byte  <= b;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    strip_sb.filter_byte(b);
    items_sent++;
  endtask

  task automatic send_message();
    foreach (msg_q[i]) begin
      send_byte(msg_q[i]);
    end
  endtask

  // Pause input until every owed byte has come out, then let the pipe settle
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (strip_sb.filtered_q.size() != 0) begin
      @(posedge clk);
    end
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  // Append the first cnt bytes of a mark, letters in random case
  function automatic void add_mark_text(int m, int cnt);
    logic [BYTE_W-1:0] c;
    for (int i = 0; i < cnt; i++) begin
      c = strip_sb.mark_txt[m][i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) begin
        c = c - 8'd32;
      end
      msg_q.push_back(c);
    end
  endfunction

  // Build one message from plain text, markup, broken markup, CRs and noise
  task automatic compose_message();
    int m;
    int len;
    msg_q.delete();
    repeat ($urandom_range(1, 6)) begin
      m   = $urandom_range(0, 6);
      len = strip_sb.mark_txt[m].len();
      case ($urandom_range(0, 9))
        0, 1, 2: msg_q.push_back(8'($urandom_range(32, 126)));
        3, 4: begin
          add_mark_text(m, len);
          if (strip_sb.mark_skip[m] == SKIP_TO_GT) begin
            repeat ($urandom_range(0, 4)) msg_q.push_back(8'($urandom_range(1, 255)));
            msg_q.push_back(CHAR_GT);
          end else if (strip_sb.mark_skip[m] == SKIP_TO_M) begin
            repeat ($urandom_range(0, 3)) msg_q.push_back(8'($urandom_range(8'h30, 8'h3b)));
            msg_q.push_back(CHAR_M);
          end
        end
        5: begin
          add_mark_text(m, $urandom_range(1, len - 1));
          msg_q.push_back(8'($urandom_range(1, 255)));
        end
        6: begin
          msg_q.push_back(CHAR_CR);
          if ($urandom_range(0, 1) == 1) begin
            msg_q.push_back(CHAR_LF);
          end
        end
        7: msg_q.push_back(8'($urandom_range(1, 255)));
        8: begin
          case ($urandom_range(0, 4))
            0:       msg_q.push_back(CHAR_GT);
            1:       msg_q.push_back(CHAR_M);
            2:       msg_q.push_back(CHAR_LF);
            3:       msg_q.push_back(CHAR_CR);
            default: msg_q.push_back(CHAR_ESC);
          endcase
        end
        default: begin
          msg_q.push_back("<");
          add_mark_text(m, len);
        end
      endcase
    end
    msg_q.push_back(CHAR_NUL);
  endtask

  task automatic run_random(int target);
    int start;
    start = items_sent;
    while (items_sent - start < target) begin
      compose_message();
      send_message();
    end
  endtask

  initial begin
    strip_sb = new();
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // High bytes, CR before markup, folded mark, end inside a skip
    msg_q = '{8'hff, 8'h80, CHAR_CR, "<", "a", "L", "T", " ", "x", CHAR_NUL};
    send_message();
    // CR as the last byte
    msg_q = '{"A", CHAR_CR, CHAR_NUL};
    send_message();
    // End with held bytes after a CR
    msg_q = '{CHAR_CR, "<", "/", CHAR_NUL};
    send_message();
    // Escape sequence skip
    msg_q = '{CHAR_ESC, "[", "1", CHAR_M, "Z", CHAR_NUL};
    send_message();

    // Sender mostly busy, receiver stalls often
    run_random(RAND_PER_PHASE);
    wait_drained();

    // Sender idles often, receiver mostly ready
    send_idle_pct = 51;
    recv_idle_pct = 9;
    run_random(RAND_PER_PHASE);
    wait_drained();

    // No idling; open with a long output hold to back up the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_off_req  = 1'b1;
    run_random(RAND_PER_PHASE);
    wait_drained();

    if (strip_sb.err_count == 0 && strip_sb.filtered_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
